>>> rtl/qau_pkg.sv
// Shared types and constants for the quaternion arithmetic unit.
// No dependencies; every other file in rtl/ imports this package.
package qau_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ACC_W  = 100;
  localparam int unsigned N_TERM = 6;
  localparam int unsigned N_LANE = 4;
  localparam int unsigned LANE_LAT = 5;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [2:0] {
    CMD_PRODUCT   = 3'd0,
    CMD_CONJUGATE = 3'd1,
    CMD_ADD       = 3'd2,
    CMD_SCALE     = 3'd3,
    CMD_DOT       = 3'd4,
    CMD_LERP      = 3'd5,
    CMD_ROTATE    = 3'd6,
    CMD_NONE      = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    SHIFT_NONE = 2'd0,
    SHIFT_16   = 2'd1,
    SHIFT_32   = 2'd2
  } shift_t;

  // One term of a lane sum: (p * q) * c, negated when neg is set.
  typedef struct packed {
    logic [DATA_W-1:0] p;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] c;
    logic              neg;
  } term_t;

  typedef struct packed {
    term_t [N_TERM-1:0] terms;
    logic               rot;
    logic [DATA_W-1:0]  u;
  } lane_req_t;

  function automatic term_t mk_term(input data_t p, input data_t q, input data_t c,
                                    input logic neg);
    term_t t;
    t.p = p;
    t.q = q;
    t.c = c;
    t.neg = neg;
    return t;
  endfunction

endpackage

>>> rtl/qau_decode.sv
// Command decoder: maps one request onto six product terms per lane.
// Depends on qau_pkg.
module qau_decode (
  input  logic                           clk,
  input  logic                           load,
  input  logic [2:0]                     command,
  input  qau_pkg::data_t                 a_x, a_y, a_z, a_w,
  input  qau_pkg::data_t                 b_x, b_y, b_z, b_w,
  input  qau_pkg::data_t                 factor,
  output qau_pkg::lane_req_t [3:0]       lanes,
  output qau_pkg::shift_t                shift
);
  import qau_pkg::*;

  lane_req_t [3:0] lanes_next;
  shift_t          shift_next;
  data_t           a [4];
  data_t           b [4];
  term_t           zero_t;

  localparam data_t ONE  = data_t'(1);
  localparam data_t UNIT = data_t'(65536);

  assign a[0] = a_x; assign a[1] = a_y; assign a[2] = a_z; assign a[3] = a_w;
  assign b[0] = b_x; assign b[1] = b_y; assign b[2] = b_z; assign b[3] = b_w;
  assign zero_t = mk_term('0, '0, '0, 1'b0);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lanes_next[i].rot = 1'b0;
      lanes_next[i].u   = b[i];
      for (int t = 0; t < 6; t++) lanes_next[i].terms[t] = zero_t;
    end
    shift_next = SHIFT_NONE;
    unique case (cmd_t'(command))
      CMD_PRODUCT: begin
        shift_next = SHIFT_16;
        lanes_next[0].terms[0] = mk_term(a[0], b[3], ONE, 1'b0);
        lanes_next[0].terms[1] = mk_term(a[3], b[0], ONE, 1'b0);
        lanes_next[0].terms[2] = mk_term(a[1], b[2], ONE, 1'b0);
        lanes_next[0].terms[3] = mk_term(a[2], b[1], ONE, 1'b1);
        lanes_next[1].terms[0] = mk_term(a[1], b[3], ONE, 1'b0);
        lanes_next[1].terms[1] = mk_term(a[3], b[1], ONE, 1'b0);
        lanes_next[1].terms[2] = mk_term(a[2], b[0], ONE, 1'b0);
        lanes_next[1].terms[3] = mk_term(a[0], b[2], ONE, 1'b1);
        lanes_next[2].terms[0] = mk_term(a[2], b[3], ONE, 1'b0);
        lanes_next[2].terms[1] = mk_term(a[3], b[2], ONE, 1'b0);
        lanes_next[2].terms[2] = mk_term(a[0], b[1], ONE, 1'b0);
        lanes_next[2].terms[3] = mk_term(a[1], b[0], ONE, 1'b1);
        lanes_next[3].terms[0] = mk_term(a[3], b[3], ONE, 1'b0);
        lanes_next[3].terms[1] = mk_term(a[0], b[0], ONE, 1'b1);
        lanes_next[3].terms[2] = mk_term(a[1], b[1], ONE, 1'b1);
        lanes_next[3].terms[3] = mk_term(a[2], b[2], ONE, 1'b1);
      end
      CMD_CONJUGATE: begin
        for (int i = 0; i < 4; i++)
          lanes_next[i].terms[0] = mk_term(a[i], ONE, ONE, (i != 3));
      end
      CMD_ADD: begin
        for (int i = 0; i < 4; i++) begin
          lanes_next[i].terms[0] = mk_term(a[i], ONE, ONE, 1'b0);
          lanes_next[i].terms[1] = mk_term(b[i], ONE, ONE, 1'b0);
        end
      end
      CMD_SCALE: begin
        shift_next = SHIFT_16;
        for (int i = 0; i < 4; i++)
          lanes_next[i].terms[0] = mk_term(a[i], factor, ONE, 1'b0);
      end
      CMD_DOT: begin
        shift_next = SHIFT_16;
        for (int i = 0; i < 4; i++)
          lanes_next[3].terms[i] = mk_term(a[i], b[i], ONE, 1'b0);
      end
      CMD_LERP: begin
        shift_next = SHIFT_16;
        for (int i = 0; i < 4; i++) begin
          lanes_next[i].terms[0] = mk_term(a[i], ONE, UNIT, 1'b0);
          lanes_next[i].terms[1] = mk_term(factor, b[i], ONE, 1'b0);
          lanes_next[i].terms[2] = mk_term(factor, a[i], ONE, 1'b1);
        end
      end
      CMD_ROTATE: begin
        // Lane i: 2*(w^2 u_i + w(v x u)_i + v_i (v.u)) - u_i, at scale 2^48.
        shift_next = SHIFT_32;
        for (int i = 0; i < 3; i++) begin
          lanes_next[i].rot = 1'b1;
          lanes_next[i].terms[0] = mk_term(a[3], a[3], b[i], 1'b0);
          lanes_next[i].terms[3] = mk_term(a[i], a[0], b[0], 1'b0);
          lanes_next[i].terms[4] = mk_term(a[i], a[1], b[1], 1'b0);
          lanes_next[i].terms[5] = mk_term(a[i], a[2], b[2], 1'b0);
        end
        lanes_next[0].terms[1] = mk_term(a[3], a[1], b[2], 1'b0);
        lanes_next[0].terms[2] = mk_term(a[3], a[2], b[1], 1'b1);
        lanes_next[1].terms[1] = mk_term(a[3], a[2], b[0], 1'b0);
        lanes_next[1].terms[2] = mk_term(a[3], a[0], b[2], 1'b1);
        lanes_next[2].terms[1] = mk_term(a[3], a[0], b[1], 1'b0);
        lanes_next[2].terms[2] = mk_term(a[3], a[1], b[0], 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      lanes <= lanes_next;
      shift <= shift_next;
    end
  end

endmodule

>>> rtl/qau_lane.sv
// One arithmetic lane: six exact (p*q)*c terms summed in a five-stage pipeline.
// Depends on qau_pkg.
module qau_lane (
  input  logic               clk,
  input  qau_pkg::lane_req_t req,
  output qau_pkg::acc_t      sum
);
  import qau_pkg::*;

  // Stage A: 32x32 pre-products.
  logic signed [63:0] pre [N_TERM];
  data_t              c_a [N_TERM];
  logic               neg_a [N_TERM];
  // Stage B: 64x32 product as two partial products.
  logic signed [63:0] ph [N_TERM];
  logic signed [64:0] pl [N_TERM];
  logic               neg_b [N_TERM];
  // Stage C: signed terms.
  acc_t               term [N_TERM];
  // Stage D: pair sums.
  acc_t               pair [3];
  logic               rot_a, rot_b, rot_c, rot_d;
  data_t              u_a, u_b, u_c, u_d;
  acc_t               total;

  always_ff @(posedge clk) begin
    for (int t = 0; t < N_TERM; t++) begin
      pre[t]   <= $signed(req.terms[t].p) * $signed(req.terms[t].q);
      c_a[t]   <= req.terms[t].c;
      neg_a[t] <= req.terms[t].neg;
      ph[t]    <= $signed(pre[t][63:32]) * c_a[t];
      pl[t]    <= $signed({1'b0, pre[t][31:0]}) * $signed({c_a[t][DATA_W-1], c_a[t]});
      neg_b[t] <= neg_a[t];
      term[t]  <= neg_b[t] ? -((acc_t'(ph[t]) <<< 32) + acc_t'(pl[t]))
                           :  ((acc_t'(ph[t]) <<< 32) + acc_t'(pl[t]));
    end
    pair[0] <= term[0] + term[1];
    pair[1] <= term[2] + term[3];
    pair[2] <= term[4] + term[5];
    sum     <= rot_d ? ((total <<< 1) - (acc_t'(u_d) <<< 32)) : total;
    rot_a <= req.rot; rot_b <= rot_a; rot_c <= rot_b; rot_d <= rot_c;
    u_a   <= req.u;   u_b   <= u_a;   u_c   <= u_b;   u_d   <= u_c;
  end

  assign total = pair[0] + pair[1] + pair[2];

endmodule

>>> rtl/qau_merge.sv
// Merge stage: rounds and saturates the four lane sums into one result.
// Depends on qau_pkg.
module qau_merge (
  input  logic                     clk,
  input  qau_pkg::acc_t [3:0]      sums,
  input  qau_pkg::shift_t          shift,
  output qau_pkg::data_t [3:0]     res,
  output logic                     saturated
);
  import qau_pkg::*;

  acc_t  rounded [4];
  logic  clip [4];
  data_t [3:0] res_next;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      unique case (shift)
        SHIFT_16: rounded[i] = (sums[i] + acc_t'(32'h0000_8000)) >>> 16;
        SHIFT_32: rounded[i] = (sums[i] + acc_t'(64'h8000_0000)) >>> 32;
        default:  rounded[i] = sums[i];
      endcase
      clip[i] = !((&rounded[i][ACC_W-1:DATA_W-1]) || !(|rounded[i][ACC_W-1:DATA_W-1]));
      res_next[i] = clip[i] ? (rounded[i][ACC_W-1] ? data_t'(32'h8000_0000)
                                                   : data_t'(32'h7FFF_FFFF))
                            : rounded[i][DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    res       <= res_next;
    saturated <= clip[0] | clip[1] | clip[2] | clip[3];
  end

endmodule

>>> rtl/quaternion_arithmetic_unit_core.sv
// Top level of the quaternion arithmetic unit: decoder, four lanes, merge stage.
// Depends on qau_pkg, qau_decode, qau_lane and qau_merge.
//
// The unit is a fully pipelined datapath that takes one request in every clock
// cycle: busy is never raised, so a request is accepted whenever start is high.
// Each request produces exactly one result, shown on r_x, r_y, r_z, r_w and
// saturated for a single cycle while done is high. The receiver cannot stall
// the pipeline, so it must take every result in the cycle it appears. The
// pipeline is one decode register, five lane stages (the 32x32 pre-product,
// the split 64x32 product, term negation, pair sums and the final sum) and
// one rounding and saturation stage.
// All values are signed Q16.16; sums are kept exact in 100-bit accumulators and
// rounded once, half up, before they are clipped to 32 bits.
module quaternion_arithmetic_unit_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  logic [2:0]     command,
  input  qau_pkg::data_t a_x, a_y, a_z, a_w,
  input  qau_pkg::data_t b_x, b_y, b_z, b_w,
  input  qau_pkg::data_t factor,
  output logic           done,
  output qau_pkg::data_t r_x, r_y, r_z, r_w,
  output logic           saturated
);
  import qau_pkg::*;

  localparam int unsigned PIPE_LAT = LANE_LAT + 2;

  lane_req_t [3:0]  lanes;
  shift_t           shift_dec;
  shift_t           shift_dly [LANE_LAT];
  acc_t [3:0]       sums;
  data_t [3:0]      res;
  logic [PIPE_LAT-1:0] valid;
  logic             accept;

  // The pipeline never stalls, so a request can always enter.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  qau_decode u_decode (
    .clk     (clk),
    .load    (accept),
    .command (command),
    .a_x     (a_x), .a_y (a_y), .a_z (a_z), .a_w (a_w),
    .b_x     (b_x), .b_y (b_y), .b_z (b_z), .b_w (b_w),
    .factor  (factor),
    .lanes   (lanes),
    .shift   (shift_dec)
  );

  // One lane per result component; lane 3 also carries the dot product.
  for (genvar i = 0; i < N_LANE; i++) begin : g_lane
    qau_lane u_lane (
      .clk (clk),
      .req (lanes[i]),
      .sum (sums[i])
    );
  end

  // The rounding position travels alongside the lanes.
  always_ff @(posedge clk) begin
    shift_dly[0] <= shift_dec;
    for (int s = 1; s < LANE_LAT; s++) shift_dly[s] <= shift_dly[s-1];
  end

  qau_merge u_merge (
    .clk       (clk),
    .sums      (sums),
    .shift     (shift_dly[LANE_LAT-1]),
    .res       (res),
    .saturated (saturated)
  );

  // Valid marks follow each request down the pipeline.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[PIPE_LAT-2:0], accept};
    end
  end

  assign done = valid[PIPE_LAT-1];
  assign r_x  = res[0];
  assign r_y  = res[1];
  assign r_z  = res[2];
  assign r_w  = res[3];

endmodule
